// File: hw/rtl/log_line_record_parser_macros.svh
// Assertion macros shared by the log line record parser modules.
`ifndef LOG_LINE_RECORD_PARSER_MACROS_SVH
`define LOG_LINE_RECORD_PARSER_MACROS_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define LLRP_ASSERT_IMP(name, ant, con, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define LLRP_ASSERT_NXT(name, ant, con, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error(msg);

`endif

// File: hw/rtl/llrp_pkg.sv
// Types, codes and helper functions of the log line record parser.
package llrp_pkg;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_SEEK,
    PH_SECONDS,
    PH_FRACTION,
    PH_NAME,
    PH_GAP,
    PH_OPTIONS,
    PH_HEX,
    PH_TEXT,
    PH_DRAIN
  } phase_t;

  // Record status codes.
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_NO_TIME  = 4'd1;
  localparam logic [3:0] ST_BAD_SEC  = 4'd2;
  localparam logic [3:0] ST_BAD_FRAC = 4'd3;
  localparam logic [3:0] ST_BAD_NAME = 4'd4;
  localparam logic [3:0] ST_BAD_DIR  = 4'd5;
  localparam logic [3:0] ST_BAD_OPT  = 4'd6;
  localparam logic [3:0] ST_BAD_HEX  = 4'd7;
  localparam logic [3:0] ST_ODD_HEX  = 4'd8;

  // Result kinds.
  localparam logic [1:0] KIND_NAME   = 2'd0;
  localparam logic [1:0] KIND_OPTION = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;
  localparam logic [1:0] KIND_RECORD = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_BASE_SEC = 1'b0;
  localparam logic CFG_BASE_US  = 1'b1;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_UP     = 8'h75;
  localparam logic [7:0] CH_DOWN   = 8'h64;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_DASH   = 8'h2d;

  // Time constants.
  localparam logic [20:0] US_PER_SEC     = 21'd1000000;
  localparam logic [20:0] US_PER_TWO_SEC = 21'd2000000;
  localparam logic [9:0]  NS_PER_US      = 10'd1000;

  // Output queue depth (power of two) and its pointer width.
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

  // Input transaction payload.
  typedef struct packed {
    logic [7:0] symbol;
    logic       line_last;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value_byte;
    logic [34:0] abs_seconds;
    logic [29:0] nanoseconds;
    logic        direction_down;
    logic        text_record;
    logic [3:0]  status;
    logic        run_last;
  } out_t;

  // Parser stage output: an optional byte result and an optional raw record.
  typedef struct packed {
    logic        byte_vld;
    logic [1:0]  byte_kind;
    logic [7:0]  byte_val;
    logic        rec_vld;
    logic [3:0]  rec_status;
    logic [29:0] rec_sec;
    logic [19:0] rec_frac;
    logic        rec_dir;
    logic        rec_text;
  } parse_t;

  // Time stage output: up to two results, packed from slot 0.
  typedef struct packed {
    logic [1:0]      cnt;
    out_t [1:0]      res;
  } pair_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  // Hex digit value; 16 marks a character that is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (is_digit(c)) v = {1'b0, c[3:0]};
    else if ((c >= 8'h61) && (c <= 8'h66)) v = 5'(c - 8'h57);
    else if ((c >= 8'h41) && (c <= 8'h46)) v = 5'(c - 8'h37);
    return v;
  endfunction

  // Weight of each fraction digit in microseconds.
  function automatic logic [16:0] frac_weight(input logic [1:0] idx);
    logic [16:0] w;
    case (idx)
      2'd0: w = 17'd100000;
      2'd1: w = 17'd10000;
      2'd2: w = 17'd1000;
      default: w = 17'd100;
    endcase
    return w;
  endfunction

  // Characters of the text protocol name.
  function automatic logic [7:0] txt_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd1: ch = 8'h58;
      default: ch = 8'h54;
    endcase
    return ch;
  endfunction

endpackage

// File: hw/rtl/llrp_parse.sv
// Character parser: line state machine and the registered parser stage.
module llrp_parse
  import llrp_pkg::*;
#(
  parameter int SECONDS_DIGITS = 9,
  parameter int NAME_CHARS     = 64,
  parameter int OPTION_CHARS   = 64
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_fire,
  input  in_t    in_data,
  output parse_t p_out
);

  localparam logic [4:0] SEC_MAX  = 5'(SECONDS_DIGITS);
  localparam logic [6:0] NAME_MAX = 7'(NAME_CHARS - 1);
  localparam logic [6:0] OPT_MAX  = 7'(OPTION_CHARS - 1);

  phase_t      phase_r, phase_nxt, phase_step;
  logic [29:0] sec_r, sec_nxt, sec_step;
  logic [4:0]  cnt_r, cnt_nxt, cnt_step;
  logic [19:0] frac_r, frac_nxt, frac_step;
  logic [6:0]  name_len_r, name_len_nxt, name_len_step;
  logic [1:0]  txt_r, txt_nxt, txt_step;
  logic        dir_r, dir_nxt, dir_step;
  logic [6:0]  opt_len_r, opt_len_nxt, opt_len_step;
  logic [3:0]  nib_r, nib_nxt, nib_step;
  logic        pend_r, pend_nxt, pend_step;
  logic [3:0]  err_r, err_nxt, err_step;
  parse_t      p_r, p_nxt;

  logic [7:0]  c;
  logic        last;
  logic        dig;
  logic [3:0]  dval;
  logic [4:0]  hv;
  logic        name_ok;
  logic        is_txt;
  logic [20:0] frac_add;
  logic        emit;
  logic [1:0]  emit_kind;
  logic [7:0]  emit_val;
  logic [3:0]  status;

  assign c        = in_data.symbol;
  assign last     = in_data.line_last;
  assign dig      = is_digit(c);
  assign dval     = c[3:0];
  assign hv       = hex_value(c);
  assign name_ok  = is_alnum(c) || (c == CH_UNDER) || (c == CH_DOT) || (c == CH_DASH);
  assign is_txt   = (name_len_r == 7'd3) && (txt_r == 2'd3);
  assign frac_add = 21'(dval) * 21'(frac_weight(cnt_r[1:0]));

  // Next phase and latched error code.
  always_comb begin
    phase_step = phase_r;
    err_step   = err_r;
    case (phase_r)
      PH_SEEK: begin
        if (dig) phase_step = PH_SECONDS;
      end
      PH_SECONDS: begin
        if (c == CH_DOT) begin
          phase_step = PH_FRACTION;
        end else if (!(dig && (cnt_r < SEC_MAX))) begin
          phase_step = PH_DRAIN;
          err_step   = ST_BAD_SEC;
        end
      end
      PH_FRACTION: begin
        if (c == CH_SPACE) begin
          phase_step = PH_NAME;
        end else if (!(dig && (cnt_r < 5'd4))) begin
          phase_step = PH_DRAIN;
          err_step   = ST_BAD_FRAC;
        end
      end
      PH_NAME: begin
        if (c == CH_SPACE) begin
          phase_step = PH_GAP;
        end else if (!(name_ok && (name_len_r < NAME_MAX))) begin
          phase_step = PH_DRAIN;
          err_step   = ST_BAD_NAME;
        end
      end
      PH_GAP: begin
        if (is_alnum(c)) begin
          if (is_txt) begin
            phase_step = PH_TEXT;
          end else if ((c == CH_UP) || (c == CH_DOWN)) begin
            phase_step = PH_OPTIONS;
          end else begin
            phase_step = PH_DRAIN;
            err_step   = ST_BAD_DIR;
          end
        end
      end
      PH_OPTIONS: begin
        if (c == CH_DOLLAR) begin
          phase_step = PH_HEX;
        end else if (!(opt_len_r < OPT_MAX)) begin
          phase_step = PH_DRAIN;
          err_step   = ST_BAD_OPT;
        end
      end
      PH_HEX: begin
        if (hv[4]) begin
          phase_step = PH_DRAIN;
          err_step   = ST_BAD_HEX;
        end
      end
      default: ;
    endcase
    phase_nxt = last ? PH_SEEK : phase_step;
    err_nxt   = last ? ST_OK : err_step;
  end

  // Field accumulators and the byte result of this character.
  always_comb begin
    sec_step      = sec_r;
    cnt_step      = cnt_r;
    frac_step     = frac_r;
    name_len_step = name_len_r;
    txt_step      = txt_r;
    dir_step      = dir_r;
    opt_len_step  = opt_len_r;
    nib_step      = nib_r;
    pend_step     = pend_r;
    emit          = 1'b0;
    emit_kind     = KIND_DATA;
    emit_val      = c;
    case (phase_r)
      PH_SEEK: begin
        if (dig) begin
          sec_step = 30'(dval);
          cnt_step = 5'd1;
        end
      end
      PH_SECONDS: begin
        if (c == CH_DOT) begin
          cnt_step  = 5'd0;
          frac_step = 20'd0;
        end else if (dig && (cnt_r < SEC_MAX)) begin
          sec_step = (sec_r << 3) + (sec_r << 1) + 30'(dval);
          cnt_step = cnt_r + 5'd1;
        end
      end
      PH_FRACTION: begin
        if ((c != CH_SPACE) && dig && (cnt_r < 5'd4)) begin
          frac_step = frac_r + frac_add[19:0];
          cnt_step  = cnt_r + 5'd1;
        end
      end
      PH_NAME: begin
        if ((c != CH_SPACE) && name_ok && (name_len_r < NAME_MAX)) begin
          if ((name_len_r < 7'd3) && (name_len_r == {5'd0, txt_r}) && (c == txt_char(txt_r)))
            txt_step = txt_r + 2'd1;
          name_len_step = name_len_r + 7'd1;
          emit          = 1'b1;
          emit_kind     = KIND_NAME;
        end
      end
      PH_GAP: begin
        if (is_alnum(c)) begin
          if (is_txt) begin
            emit = 1'b1;
          end else if ((c == CH_UP) || (c == CH_DOWN)) begin
            dir_step     = (c == CH_DOWN);
            opt_len_step = 7'd0;
          end
        end
      end
      PH_OPTIONS: begin
        if (c == CH_DOLLAR) begin
          pend_step = 1'b0;
        end else if (opt_len_r < OPT_MAX) begin
          opt_len_step = opt_len_r + 7'd1;
          emit         = 1'b1;
          emit_kind    = KIND_OPTION;
        end
      end
      PH_HEX: begin
        if (!hv[4]) begin
          if (pend_r) begin
            emit      = 1'b1;
            emit_val  = {nib_r, hv[3:0]};
            pend_step = 1'b0;
          end else begin
            nib_step  = hv[3:0];
            pend_step = 1'b1;
          end
        end
      end
      PH_TEXT: begin
        emit = 1'b1;
      end
      default: ;
    endcase

    // Status of a line that ends on this character.
    case (phase_step)
      PH_SEEK:     status = ST_NO_TIME;
      PH_SECONDS:  status = ST_BAD_SEC;
      PH_FRACTION: status = ST_BAD_FRAC;
      PH_NAME:     status = ST_BAD_NAME;
      PH_GAP:      status = ST_BAD_DIR;
      PH_OPTIONS:  status = ST_BAD_OPT;
      PH_HEX:      status = pend_step ? ST_ODD_HEX : ST_OK;
      PH_TEXT:     status = ST_OK;
      default:     status = err_step;
    endcase

    // The line state returns to reset after every record.
    sec_nxt      = last ? 30'd0 : sec_step;
    cnt_nxt      = last ? 5'd0 : cnt_step;
    frac_nxt     = last ? 20'd0 : frac_step;
    name_len_nxt = last ? 7'd0 : name_len_step;
    txt_nxt      = last ? 2'd0 : txt_step;
    dir_nxt      = last ? 1'b0 : dir_step;
    opt_len_nxt  = last ? 7'd0 : opt_len_step;
    nib_nxt      = last ? 4'd0 : nib_step;
    pend_nxt     = last ? 1'b0 : pend_step;

    // Stage register contents.
    p_nxt.byte_vld   = in_fire && emit;
    p_nxt.byte_kind  = emit_kind;
    p_nxt.byte_val   = emit_val;
    p_nxt.rec_vld    = in_fire && last;
    p_nxt.rec_status = status;
    p_nxt.rec_sec    = sec_step;
    p_nxt.rec_frac   = frac_step;
    p_nxt.rec_dir    = (phase_step == PH_TEXT) ? 1'b0 : dir_step;
    p_nxt.rec_text   = (phase_step == PH_TEXT);
  end

  // Line state advances on each accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SEEK;
      sec_r      <= '0;
      cnt_r      <= '0;
      frac_r     <= '0;
      name_len_r <= '0;
      txt_r      <= '0;
      dir_r      <= 1'b0;
      opt_len_r  <= '0;
      nib_r      <= '0;
      pend_r     <= 1'b0;
      err_r      <= ST_OK;
    end else if (in_fire) begin
      phase_r    <= phase_nxt;
      sec_r      <= sec_nxt;
      cnt_r      <= cnt_nxt;
      frac_r     <= frac_nxt;
      name_len_r <= name_len_nxt;
      txt_r      <= txt_nxt;
      dir_r      <= dir_nxt;
      opt_len_r  <= opt_len_nxt;
      nib_r      <= nib_nxt;
      pend_r     <= pend_nxt;
      err_r      <= err_nxt;
    end
  end

  // Parser stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= '0;
    end else begin
      p_r <= p_nxt;
    end
  end

  assign p_out = p_r;

  `include "log_line_record_parser_macros.svh"

  `LLRP_ASSERT_NXT(a_line_clears, in_fire && last, (phase_r == PH_SEEK) && (err_r == ST_OK), "line state not cleared after record")
  `LLRP_ASSERT_IMP(a_err_drains, err_r != ST_OK, phase_r == PH_DRAIN, "error latched outside drain phase")
  `LLRP_ASSERT_IMP(a_pend_in_hex, pend_r, (phase_r == PH_HEX) || (phase_r == PH_DRAIN), "nibble pending outside hex data")

endmodule

// File: hw/rtl/llrp_time.sv
// Time stage: adds the capture base to a record and orders the results of one character.
module llrp_time
  import llrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  parse_t      p_in,
  input  logic [33:0] base_sec,
  input  logic [19:0] base_us,
  output pair_t       t_out
);

  pair_t       t_r, t_nxt;
  logic [20:0] us_sum;
  logic        ge1, ge2;
  logic [20:0] us_rem;
  logic [29:0] ns;
  logic [34:0] abs_sec;
  logic        time_ok;
  out_t        byte_res, rec_res;

  // Microsecond sum with at most one second carried; remainder below one second.
  assign us_sum  = {1'b0, base_us} + {1'b0, p_in.rec_frac};
  assign ge1     = us_sum >= US_PER_SEC;
  assign ge2     = us_sum >= US_PER_TWO_SEC;
  assign us_rem  = us_sum - (ge2 ? US_PER_TWO_SEC : (ge1 ? US_PER_SEC : 21'd0));
  assign ns      = 30'(us_rem[19:0]) * 30'(NS_PER_US);
  assign abs_sec = 35'(base_sec) + 35'(p_in.rec_sec) + 35'(ge1);
  assign time_ok = (p_in.rec_status == ST_OK) || (p_in.rec_status == ST_ODD_HEX);

  // Build both results; the record always closes the run.
  always_comb begin
    byte_res            = '0;
    byte_res.kind       = p_in.byte_kind;
    byte_res.value_byte = p_in.byte_val;
    byte_res.run_last   = !p_in.rec_vld;

    rec_res        = '0;
    rec_res.kind   = KIND_RECORD;
    rec_res.status = p_in.rec_status;
    rec_res.run_last = 1'b1;
    if (time_ok) begin
      rec_res.abs_seconds    = abs_sec;
      rec_res.nanoseconds    = ns;
      rec_res.direction_down = p_in.rec_dir;
      rec_res.text_record    = p_in.rec_text;
    end

    t_nxt.res[0] = p_in.byte_vld ? byte_res : rec_res;
    t_nxt.res[1] = rec_res;
    t_nxt.cnt    = {1'b0, p_in.byte_vld} + {1'b0, p_in.rec_vld};
  end

  // Result register of the time stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r.cnt <= 2'd0;
    end else begin
      t_r.cnt <= t_nxt.cnt;
    end
    t_r.res <= t_nxt.res;
  end

  assign t_out = t_r;

endmodule

// File: hw/rtl/llrp_fifo.sv
// Output queue that takes up to two results per cycle and delivers one.
module llrp_fifo
  import llrp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  pair_t                push,
  input  logic                 pop,
  output logic                 not_empty,
  output out_t                 head,
  output logic [OUT_PTR_W:0]   count
);

  out_t                 mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OUT_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OUT_PTR_W:0]   cnt_r, cnt_nxt;
  logic [OUT_PTR_W-1:0] wr_ptr_p1;

  assign wr_ptr_p1  = wr_ptr_r + 1'b1;
  assign wr_ptr_nxt = wr_ptr_r + OUT_PTR_W'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + OUT_PTR_W'(pop);
  assign cnt_nxt    = cnt_r + (OUT_PTR_W + 1)'(push.cnt) - (OUT_PTR_W + 1)'(pop);

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_ptr_r] <= push.res[0];
    if (push.cnt == 2'd2) mem_r[wr_ptr_p1] <= push.res[1];
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign not_empty = cnt_r != '0;
  assign head      = mem_r[rd_ptr_r];
  assign count     = cnt_r;

  `include "log_line_record_parser_macros.svh"

  `LLRP_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= (OUT_PTR_W + 1)'(OUT_DEPTH), "queue count out of range")
  `LLRP_ASSERT_IMP(a_no_overflow, push.cnt != 2'd0, ({3'b0, push.cnt} + 5'(cnt_r)) <= (5'(OUT_DEPTH) + {4'b0, pop}), "queue overflow")
  `LLRP_ASSERT_IMP(a_empty_ptrs, cnt_r == '0, rd_ptr_r == wr_ptr_r, "empty queue with unequal pointers")

endmodule

// File: hw/rtl/log_line_record_parser.sv
// Top level of the log line record parser.
//
//   Channel   Direction  Handshake          Payload
//   in_       input      in_valid/in_stall   in_data   (symbol, line_last)
//   out_      output     out_valid/out_stall out_data  (one result transaction)
//   cfg_      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One character is accepted per cycle while in_stall is low; the last character of a line
// gives up to two results. Results pass through the parser stage, then the time stage, into
// an eight-entry output queue, which drains one per cycle while out_stall is low.
// in_stall rises when the queue plus results still in the two stages leave no room for two.
// rst_n is synchronous; it clears the line state, the queue and the base time registers.
// cfg_ready is always high.
module log_line_record_parser
  import llrp_pkg::*;
#(
  parameter int SECONDS_DIGITS = 9,
  parameter int NAME_CHARS     = 64,
  parameter int OPTION_CHARS   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [33:0] cfg_data
);

  logic [33:0]        base_sec_r;
  logic [19:0]        base_us_r;
  logic               in_fire;
  logic               pop;
  parse_t             p_stage;
  pair_t              t_stage;
  logic [OUT_PTR_W:0] q_count;
  logic [OUT_PTR_W+1:0] in_flight;

  // Base time registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_sec_r <= '0;
      base_us_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BASE_SEC: base_sec_r <= cfg_data;
        CFG_BASE_US:  base_us_r  <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // Input flow control: reserve room for two results per accepted character.
  assign in_flight = (OUT_PTR_W + 2)'(q_count)
                   + (OUT_PTR_W + 2)'(p_stage.byte_vld) + (OUT_PTR_W + 2)'(p_stage.rec_vld)
                   + (OUT_PTR_W + 2)'(t_stage.cnt);
  assign in_stall  = in_flight > (OUT_PTR_W + 2)'(OUT_DEPTH - 2);
  assign in_fire   = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  llrp_parse #(
    .SECONDS_DIGITS (SECONDS_DIGITS),
    .NAME_CHARS     (NAME_CHARS),
    .OPTION_CHARS   (OPTION_CHARS)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_data (in_data),
    .p_out   (p_stage)
  );

  llrp_time u_time (
    .clk      (clk),
    .rst_n    (rst_n),
    .p_in     (p_stage),
    .base_sec (base_sec_r),
    .base_us  (base_us_r),
    .t_out    (t_stage)
  );

  llrp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (t_stage),
    .pop       (pop),
    .not_empty (out_valid),
    .head      (out_data),
    .count     (q_count)
  );

endmodule

// File: tb/sv/log_line_record_parser_tb.sv
// Self-checking testbench of the log line record parser: directed and random lines.
`timescale 1ns / 100ps

module log_line_record_parser_tb
  import llrp_pkg::*;
();

  localparam int SEC_DIGITS    = 9;
  localparam int NAME_LIMIT    = 64;
  localparam int OPTION_LIMIT  = 64;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int CHUNK_CHARS   = 150;
  localparam logic [23:0] TXT_WORD = "TXT";

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [33:0] cfg_data = '0;

  log_line_record_parser #(
    .SECONDS_DIGITS(SEC_DIGITS),
    .NAME_CHARS    (NAME_LIMIT),
    .OPTION_CHARS  (OPTION_LIMIT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Character stream waiting to be sent and results still owed by the block.
  in_t  pending_chars [$];
  out_t expected_results [$];
  logic [7:0] line_buf [$];

  // Shadow of the time base registers.
  logic [33:0] base_sec_reg = '0;
  logic [19:0] base_us_reg = '0;

  // Shadow of the line parsing state.
  phase_t      ph;
  logic [29:0] sec_acc;
  logic [4:0]  dig_cnt;
  logic [19:0] frac_acc;
  logic [6:0]  name_len;
  logic [1:0]  txt_cnt;
  logic        dir_flag;
  logic [6:0]  opt_len;
  logic [3:0]  nib;
  logic        nib_pend;
  logic [3:0]  err_code;

  int errors = 0;
  int cycles = 0;
  int results_checked = 0;
  int chars_queued = 0;
  int lines_parsed = 0;
  int text_records = 0;
  int error_records = 0;
  int base_settings = 1;
  int in_wait = 0;
  int out_wait = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Character classes and random characters.
  function automatic bit char_is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit char_is_word(input logic [7:0] c);
    return char_is_num(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [4:0] hex_of(input logic [7:0] c);
    if (char_is_num(c)) return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    return 5'h10;
  endfunction

  function automatic logic [16:0] frac_scale(input logic [4:0] pos);
    case (pos)
      5'd0: return 17'd100000;
      5'd1: return 17'd10000;
      5'd2: return 17'd1000;
      default: return 17'd100;
    endcase
  endfunction

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic logic [7:0] rand_any();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'("0" + r);
    if (r < 16) return 8'("a" + r - 10);
    return 8'("A" + r - 16);
  endfunction

  function automatic logic [7:0] rand_name_char();
    int r;
    r = $urandom_range(0, 64);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("a" + r - 10);
    if (r < 62) return 8'("A" + r - 36);
    if (r == 62) return CH_UNDER;
    if (r == 63) return CH_DOT;
    return CH_DASH;
  endfunction

  function automatic out_t byte_result(input logic [1:0] kind, input logic [7:0] val);
    out_t r;
    r = '0;
    r.kind = kind;
    r.value_byte = val;
    return r;
  endfunction

  task automatic clear_line_state();
    ph = PH_SEEK;
    sec_acc = '0;
    dig_cnt = '0;
    frac_acc = '0;
    name_len = '0;
    txt_cnt = '0;
    dir_flag = 1'b0;
    opt_len = '0;
    nib = '0;
    nib_pend = 1'b0;
    err_code = '0;
  endtask

  task automatic abort_line(input logic [3:0] code);
    err_code = code;
    ph = PH_DRAIN;
  endtask

  // Advance the shadow parser by one character and queue the results it owes.
  task automatic predict_results(input in_t item);
    out_t res [2];
    int n;
    logic [7:0] c;
    logic [4:0] hv;
    logic at_txt;
    logic [3:0] st;
    longint unsigned us_total;
    longint unsigned carry;
    c = item.symbol;
    at_txt = (name_len == 7'd3) && (txt_cnt == 2'd3);
    n = 0;
    res[0] = '0;
    res[1] = '0;
    case (ph)
      PH_SEEK: begin
        if (char_is_num(c)) begin
          sec_acc = 30'(c - "0");
          dig_cnt = 5'd1;
          ph = PH_SECONDS;
        end
      end
      PH_SECONDS: begin
        if (c == CH_DOT) begin
          ph = PH_FRACTION;
          dig_cnt = '0;
          frac_acc = '0;
        end else if (char_is_num(c) && dig_cnt < SEC_DIGITS) begin
          sec_acc = sec_acc * 30'd10 + 30'(c - "0");
          dig_cnt++;
        end else begin
          abort_line(ST_BAD_SEC);
        end
      end
      PH_FRACTION: begin
        if (c == CH_SPACE) begin
          ph = PH_NAME;
        end else if (char_is_num(c) && dig_cnt < 4) begin
          frac_acc = frac_acc + 20'(frac_scale(dig_cnt)) * 20'(c - "0");
          dig_cnt++;
        end else begin
          abort_line(ST_BAD_FRAC);
        end
      end
      PH_NAME: begin
        if (c == CH_SPACE) begin
          ph = PH_GAP;
        end else if ((char_is_word(c) || c == CH_UNDER || c == CH_DOT || c == CH_DASH) &&
                     name_len < NAME_LIMIT - 1) begin
          if (name_len < 3 && txt_cnt == name_len &&
              c == TXT_WORD[23 - 8 * name_len -: 8])
            txt_cnt++;
          name_len++;
          res[n++] = byte_result(KIND_NAME, c);
        end else begin
          abort_line(ST_BAD_NAME);
        end
      end
      PH_GAP: begin
        if (char_is_word(c)) begin
          if (at_txt) begin
            ph = PH_TEXT;
            res[n++] = byte_result(KIND_DATA, c);
          end else if (c == CH_UP || c == CH_DOWN) begin
            dir_flag = (c == CH_DOWN);
            opt_len = '0;
            ph = PH_OPTIONS;
          end else begin
            abort_line(ST_BAD_DIR);
          end
        end
      end
      PH_OPTIONS: begin
        if (c == CH_DOLLAR) begin
          ph = PH_HEX;
          nib_pend = 1'b0;
        end else if (opt_len < OPTION_LIMIT - 1) begin
          opt_len++;
          res[n++] = byte_result(KIND_OPTION, c);
        end else begin
          abort_line(ST_BAD_OPT);
        end
      end
      PH_HEX: begin
        hv = hex_of(c);
        if (hv[4]) begin
          abort_line(ST_BAD_HEX);
        end else if (nib_pend) begin
          res[n++] = byte_result(KIND_DATA, {nib, hv[3:0]});
          nib_pend = 1'b0;
        end else begin
          nib = hv[3:0];
          nib_pend = 1'b1;
        end
      end
      PH_TEXT: res[n++] = byte_result(KIND_DATA, c);
      default: ;
    endcase

    // The last character closes the line with a record, time-stamped for OK and odd-hex status.
    if (item.line_last) begin
      case (ph)
        PH_SEEK:     st = ST_NO_TIME;
        PH_SECONDS:  st = ST_BAD_SEC;
        PH_FRACTION: st = ST_BAD_FRAC;
        PH_NAME:     st = ST_BAD_NAME;
        PH_GAP:      st = ST_BAD_DIR;
        PH_OPTIONS:  st = ST_BAD_OPT;
        PH_HEX:      st = nib_pend ? ST_ODD_HEX : ST_OK;
        PH_TEXT:     st = ST_OK;
        default:     st = err_code;
      endcase
      res[n] = byte_result(KIND_RECORD, 8'h00);
      res[n].status = st;
      if (st == ST_OK || st == ST_ODD_HEX) begin
        us_total = 64'(base_us_reg) + 64'(frac_acc);
        carry = (us_total >= US_PER_SEC) ? 64'd1 : 64'd0;
        res[n].abs_seconds = 35'(64'(base_sec_reg) + 64'(sec_acc) + carry);
        res[n].nanoseconds = 30'((us_total % US_PER_SEC) * NS_PER_US);
        res[n].direction_down = (ph == PH_TEXT) ? 1'b0 : dir_flag;
        res[n].text_record = (ph == PH_TEXT);
        if (ph == PH_TEXT) text_records++;
      end else begin
        error_records++;
      end
      n++;
      lines_parsed++;
      clear_line_state();
    end

    if (n > 0) res[n - 1].run_last = 1'b1;
    for (int i = 0; i < n; i++) expected_results.push_back(res[i]);
  endtask

  task automatic report_error(input string msg);
    errors++;
    if (errors <= 40) $display("ERROR at cycle %0d: %s", cycles, msg);
  endtask

  task automatic compare_field(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got %0h, expected %0h",
                             results_checked, field, got, want));
  endtask

  // Compare one result transaction with the oldest outstanding expectation.
  task automatic check_result(input out_t got);
    out_t want;
    if (expected_results.size() == 0) begin
      report_error($sformatf("unexpected result kind %0d value %02h status %0d",
                             got.kind, got.value_byte, got.status));
      return;
    end
    want = expected_results.pop_front();
    results_checked++;
    compare_field("kind", got.kind, want.kind);
    compare_field("value_byte", got.value_byte, want.value_byte);
    compare_field("abs_seconds", got.abs_seconds, want.abs_seconds);
    compare_field("nanoseconds", got.nanoseconds, want.nanoseconds);
    compare_field("direction_down", got.direction_down, want.direction_down);
    compare_field("text_record", got.text_record, want.text_record);
    compare_field("status", got.status, want.status);
    compare_field("run_last", got.run_last, want.run_last);
  endtask

  // Line assembly: characters collect in line_buf and move to the send queue.
  task automatic put_char(input logic [7:0] c);
    line_buf.push_back(c);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  task automatic end_line();
    in_t item;
    if (line_buf.size() == 0) put_char(rand_any());
    for (int i = 0; i < line_buf.size(); i++) begin
      item.symbol = line_buf[i];
      item.line_last = (i == line_buf.size() - 1);
      pending_chars.push_back(item);
    end
    chars_queued += line_buf.size();
    line_buf.delete();
  endtask

  // A mostly well-formed line with random content, either hex data or pass-through text.
  task automatic build_good_line(input bit as_text);
    int k;
    logic [7:0] c;
    repeat ($urandom_range(0, 2)) begin
      c = rand_any();
      put_char(char_is_num(c) ? 8'h3a : c);
    end
    k = ($urandom_range(0, 19) == 0) ? SEC_DIGITS + 1 : $urandom_range(1, SEC_DIGITS);
    repeat (k) put_char(rand_digit());
    put_char(CH_DOT);
    k = ($urandom_range(0, 19) == 0) ? 5 : $urandom_range(0, 4);
    repeat (k) put_char(rand_digit());
    put_char(CH_SPACE);
    if (as_text) begin
      put_str("TXT");
    end else begin
      if ($urandom_range(0, 24) == 0) k = $urandom_range(NAME_LIMIT - 4, NAME_LIMIT);
      else if ($urandom_range(0, 19) == 0) k = 0;
      else k = $urandom_range(1, 8);
      repeat (k) put_char(rand_name_char());
    end
    put_char(CH_SPACE);
    repeat ($urandom_range(0, 2)) begin
      c = rand_any();
      put_char(char_is_word(c) ? CH_DASH : c);
    end
    if (as_text) begin
      repeat ($urandom_range(0, 10)) put_char(rand_any());
    end else begin
      put_char($urandom_range(0, 1) ? CH_DOWN : CH_UP);
      k = ($urandom_range(0, 29) == 0) ? $urandom_range(OPTION_LIMIT - 3, OPTION_LIMIT)
                                        : $urandom_range(0, 6);
      repeat (k) begin
        c = rand_any();
        put_char(c == CH_DOLLAR ? 8'h25 : c);
      end
      put_char(CH_DOLLAR);
      k = 2 * $urandom_range(0, 5) + (($urandom_range(0, 7) == 0) ? 1 : 0);
      repeat (k) put_char(rand_hex_char());
    end
  endtask

  task automatic random_line();
    int r;
    int keep;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      build_good_line(r >= 55 && r < 70);
      // Broken lines: one character replaced or the tail cut off.
      if (r >= 70) begin
        if ($urandom_range(0, 1)) begin
          line_buf[$urandom_range(0, line_buf.size() - 1)] = rand_any();
        end else begin
          keep = $urandom_range(1, line_buf.size());
          while (line_buf.size() > keep) void'(line_buf.pop_back());
        end
      end
    end else begin
      repeat ($urandom_range(1, 12)) put_char(rand_any());
    end
    end_line();
  endtask

  // Wait until every character has been sent and every result has come back.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_chars.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [33:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    if (idx == CFG_BASE_SEC) base_sec_reg = val;
    else base_us_reg = val[19:0];
    cfg_valid <= 1'b0;
  endtask

  // Sender: one character per transaction with a random gap after each.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_results(in_data);
        in_wait = draw_wait(in_calm);
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
      end
      if (!in_valid || !in_stall) begin
        if (in_wait > 0) begin
          in_wait--;
          in_valid <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= pending_chars.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result transaction, then stall for a random count.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
        out_wait = draw_wait(out_calm);
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      end else if (out_wait > 0) begin
        out_wait--;
      end
      out_stall <= (out_wait != 0);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycles, expected_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [33:0] sec_set [5];
    logic [19:0] us_set [5];
    int target;
    clear_line_state();
    sec_set[0] = 34'h3_ffff_ffff;
    us_set[0]  = 20'd999999;
    sec_set[1] = 34'h0;
    us_set[1]  = 20'd0;
    sec_set[2] = {2'($urandom_range(0, 3)), 32'($urandom())};
    us_set[2]  = 20'($urandom_range(0, 999999));
    sec_set[3] = {2'($urandom_range(0, 3)), 32'($urandom())};
    us_set[3]  = 20'hfffff;
    sec_set[4] = 34'h3_ffff_ffff;
    us_set[4]  = 20'hfffff;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines, run with the time base at its reset value.
    put_str("12.5 ABC u opt$0aFF"); end_line();
    put_str("0.0000 x d$"); end_line();
    put_str("999999999.9999 TXT  -hello"); end_line();
    put_str("1234567890.1 a u$"); end_line();
    put_str("1.12345 a u$"); end_line();
    put_str("abc"); end_line();
    put_str("5"); end_line();
    put_str("12."); end_line();
    put_str("12.3 nm"); end_line();
    put_str("12.3 nm "); end_line();
    put_str("12.3 nm u ab"); end_line();
    put_str("12.3 TXT "); end_line();
    put_str("1.0 n u$0g12"); end_line();
    put_str("1.0 n u$abc"); end_line();
    put_str("1.0 n x$00"); end_line();
    put_str("1.0 n@ u$00"); end_line();
    put_str("2.5 TXTX u$10"); end_line();
    put_str("2.5 txt d$10"); end_line();
    put_str("[42.07 a_b.c-d -:d opts$Aa"); end_line();
    put_str("1..5 a u$"); end_line();
    put_str("1.5 "); repeat (NAME_LIMIT - 1) put_char("n"); put_str(" u$11"); end_line();
    put_str("1.5 "); repeat (NAME_LIMIT) put_char("n"); put_str(" u$11"); end_line();
    put_str("3.25 op u"); repeat (OPTION_LIMIT - 1) put_char("o"); put_str("$22"); end_line();
    put_str("3.25 op d"); repeat (OPTION_LIMIT) put_char("o"); put_str("$22"); end_line();
    put_str("7.25 Op d"); put_char(8'hff); put_char(8'h80); put_str("$7e"); end_line();
    put_str("3.5 TXT "); put_char(8'h00); put_char(8'hff); end_line();
    wait_idle();

    // Random lines in chunks, each under its own time base; the sender pauses between them.
    for (int ph_i = 0; ph_i < 5; ph_i++) begin
      write_reg(CFG_BASE_SEC, sec_set[ph_i]);
      write_reg(CFG_BASE_US, {14'd0, us_set[ph_i]});
      base_settings++;
      target = chars_queued + CHUNK_CHARS;
      while (chars_queued < target) random_line();
      wait_idle();
    end

    if (expected_results.size() != 0)
      report_error($sformatf("%0d expected results never arrived", expected_results.size()));

    $display("Checked %0d results from %0d characters in %0d lines (%0d text, %0d errored).",
             results_checked, chars_queued, lines_parsed, text_records, error_records);
    $display("Used %0d time base settings, both register extremes and an oversized fraction.",
             base_settings);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches found.", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
